FILE: sv/tcw_pkg.sv
// Shared constants for the text console writer: default geometry, action codes,
// field widths and special character codes. No dependencies.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;

    // Action codes carried by a command transfer
    localparam logic [ACTION_W-1:0] ACT_PRINT       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PRINT_COLOR = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FILL        = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ        = 3'd4;

    localparam logic [BYTE_W-1:0] CHAR_BLANK   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

endpackage

FILE: sv/tcw_if.sv
// Valid/ready channel interfaces for console commands and console results.
// Depends on tcw_pkg for field widths.
interface tcw_cmd_if #(
    parameter int CELL_W = 11
);
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   char_code;
    logic [BYTE_W-1:0]   color;
    logic [CELL_W-1:0]   cell_index;

    modport source (output valid, action, char_code, color, cell_index, input ready);
    modport sink   (input valid, action, char_code, color, cell_index, output ready);
endinterface

interface tcw_rsp_if #(
    parameter int CELL_W = 11
);
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cursor_cell;
    logic [BYTE_W-1:0] read_char;
    logic [BYTE_W-1:0] read_color;
    logic              scrolled;

    modport source (output valid, cursor_cell, read_char, read_color, scrolled, input ready);
    modport sink   (input valid, cursor_cell, read_char, read_color, scrolled, output ready);
endinterface

FILE: sv/tcw_byte_mem.sv
// Single-port-write, single-port-read byte store with registered read data.
// Holds one screen plane (characters or colors). Depends on tcw_pkg.
module tcw_byte_mem #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [tcw_pkg::BYTE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [tcw_pkg::BYTE_W-1:0] o_rdata
);
    import tcw_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/text_console_writer_core.sv
// Text console writer: sequencer over a character plane and a color plane.
// Depends on tcw_pkg, tcw_cmd_if / tcw_rsp_if and tcw_byte_mem.
// Command path: print goes to S_PRINT, first scrolling in S_SCROLL if the cursor is
//   past the last cell; clear or fill sweep in S_SWEEP; read takes S_RADDR, S_RDATA.
// Every path ends in S_DONE. Throughput: one command at a time; a scroll or clear or fill
//   writes one cell per cycle (single write port of each plane).
// Reset: cursor homes to cell 0, no result pending; screen contents are not cleared.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcw_cmd_if.sink   i_cmd,
    tcw_rsp_if.source o_rsp
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [CELL_W-1:0] C_CELLS    = CELL_W'(CELLS);
    localparam logic [CELL_W-1:0] C_COLS     = CELL_W'(COLUMNS);
    localparam logic [CELL_W-1:0] C_LAST_ROW = CELL_W'(CELLS - COLUMNS);
    localparam logic [CELL_W-1:0] C_LAST     = CELL_W'(CELLS - 1);
    localparam logic [COL_W-1:0]  C_COL_LAST = COL_W'(COLUMNS - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCROLL = 3'd1;
    localparam logic [2:0] S_PRINT  = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_RADDR  = 3'd4;
    localparam logic [2:0] S_RDATA  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [CELL_W-1:0]   r_cur, n_cur;
    logic [COL_W-1:0]    r_colp, n_colp;
    logic [CELL_W-1:0]   r_cnt, n_cnt;
    logic [ACTION_W-1:0] r_act, n_act;
    logic [BYTE_W-1:0]   r_ch, n_ch;
    logic [BYTE_W-1:0]   r_col, n_col;
    logic [CELL_W-1:0]   r_idx, n_idx;
    logic [BYTE_W-1:0]   r_rch, n_rch;
    logic [BYTE_W-1:0]   r_rcol, n_rcol;
    logic                r_scr, n_scr;

    logic                r_ovalid, n_ovalid;
    logic [CELL_W-1:0]   r_ocur, n_ocur;
    logic [BYTE_W-1:0]   r_orch, n_orch;
    logic [BYTE_W-1:0]   r_orcol, n_orcol;
    logic                r_oscr, n_oscr;

    logic                chr_we, chr_re, clr_we, clr_re;
    logic [ADDR_W-1:0]   chr_waddr, chr_raddr, clr_waddr, clr_raddr;
    logic [BYTE_W-1:0]   chr_wdata, clr_wdata, chr_rdata, clr_rdata;

    logic                cmd_xfer;
    logic                rsp_free;

    assign cmd_xfer = i_cmd.valid && i_cmd.ready;
    assign rsp_free = !r_ovalid || o_rsp.ready;

    tcw_byte_mem #(.DEPTH(CELLS), .ADDR_W(ADDR_W)) u_chars (
        .i_clk   (i_clk),
        .i_we    (chr_we),
        .i_waddr (chr_waddr),
        .i_wdata (chr_wdata),
        .i_re    (chr_re),
        .i_raddr (chr_raddr),
        .o_rdata (chr_rdata)
    );

    tcw_byte_mem #(.DEPTH(CELLS), .ADDR_W(ADDR_W)) u_colors (
        .i_clk   (i_clk),
        .i_we    (clr_we),
        .i_waddr (clr_waddr),
        .i_wdata (clr_wdata),
        .i_re    (clr_re),
        .i_raddr (clr_raddr),
        .o_rdata (clr_rdata)
    );

    // Sequencer and memory access control
    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_colp   = r_colp;
        n_cnt    = r_cnt;
        n_act    = r_act;
        n_ch     = r_ch;
        n_col    = r_col;
        n_idx    = r_idx;
        n_rch    = r_rch;
        n_rcol   = r_rcol;
        n_scr    = r_scr;
        n_ovalid = r_ovalid;
        n_ocur   = r_ocur;
        n_orch   = r_orch;
        n_orcol  = r_orcol;
        n_oscr   = r_oscr;

        chr_we    = 1'b0;
        chr_waddr = r_cur[ADDR_W-1:0];
        chr_wdata = r_ch;
        chr_re    = 1'b0;
        chr_raddr = r_idx[ADDR_W-1:0];
        clr_we    = 1'b0;
        clr_waddr = r_cur[ADDR_W-1:0];
        clr_wdata = r_col;
        clr_re    = 1'b0;
        clr_raddr = r_idx[ADDR_W-1:0];

        // Drop the result once the sink takes it
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (cmd_xfer) begin
                    n_act  = i_cmd.action;
                    n_ch   = i_cmd.char_code;
                    n_col  = i_cmd.color;
                    n_idx  = i_cmd.cell_index;
                    n_rch  = '0;
                    n_rcol = '0;
                    n_scr  = 1'b0;
                    n_cnt  = '0;
                    case (i_cmd.action)
                        ACT_PRINT, ACT_PRINT_COLOR: begin
                            n_state = (r_cur == C_CELLS) ? S_SCROLL : S_PRINT;
                        end
                        ACT_CLEAR, ACT_FILL: begin
                            n_state = S_SWEEP;
                        end
                        ACT_READ: begin
                            n_state = S_RADDR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Read cell cnt+COLUMNS, write the previous read one row up; blank the last row
            S_SCROLL: begin
                chr_re    = (r_cnt < C_LAST_ROW);
                chr_raddr = ADDR_W'(r_cnt + C_COLS);
                if (r_cnt != '0) begin
                    chr_we    = 1'b1;
                    chr_waddr = ADDR_W'(r_cnt - CELL_W'(1));
                    chr_wdata = (r_cnt <= C_LAST_ROW) ? chr_rdata : CHAR_BLANK;
                end
                n_cnt = r_cnt + CELL_W'(1);
                if (r_cnt == C_CELLS) begin
                    n_cur   = C_LAST_ROW;
                    n_colp  = '0;
                    n_scr   = 1'b1;
                    n_state = S_PRINT;
                end
            end

            // Place the character or advance to the next row start
            S_PRINT: begin
                if (r_ch == CHAR_NEWLINE) begin
                    n_cur  = r_cur + C_COLS - CELL_W'(r_colp);
                    n_colp = '0;
                end else begin
                    chr_we = 1'b1;
                    clr_we = (r_act == ACT_PRINT_COLOR);
                    n_cur  = r_cur + CELL_W'(1);
                    n_colp = (r_colp == C_COL_LAST) ? '0 : r_colp + COL_W'(1);
                end
                n_state = S_DONE;
            end

            // Clear characters or fill colors, one cell per cycle
            S_SWEEP: begin
                chr_waddr = r_cnt[ADDR_W-1:0];
                chr_wdata = CHAR_BLANK;
                clr_waddr = r_cnt[ADDR_W-1:0];
                chr_we    = (r_act == ACT_CLEAR);
                clr_we    = (r_act == ACT_FILL);
                n_cnt     = r_cnt + CELL_W'(1);
                if (r_cnt == C_LAST) begin
                    if (r_act == ACT_CLEAR) begin
                        n_cur  = '0;
                        n_colp = '0;
                    end
                    n_state = S_DONE;
                end
            end

            S_RADDR: begin
                chr_re  = (r_idx < C_CELLS);
                clr_re  = (r_idx < C_CELLS);
                n_state = S_RDATA;
            end

            S_RDATA: begin
                if (r_idx < C_CELLS) begin
                    n_rch  = chr_rdata;
                    n_rcol = clr_rdata;
                end
                n_state = S_DONE;
            end

            // Hold until the result register is free
            S_DONE: begin
                if (rsp_free) begin
                    n_ovalid = 1'b1;
                    n_ocur   = r_cur;
                    n_orch   = r_rch;
                    n_orcol  = r_rcol;
                    n_oscr   = r_scr;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_colp   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_colp   <= n_colp;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_act   <= n_act;
        r_ch    <= n_ch;
        r_col   <= n_col;
        r_idx   <= n_idx;
        r_rch   <= n_rch;
        r_rcol  <= n_rcol;
        r_scr   <= n_scr;
        r_ocur  <= n_ocur;
        r_orch  <= n_orch;
        r_orcol <= n_orcol;
        r_oscr  <= n_oscr;
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.cursor_cell = r_ocur;
    assign o_rsp.read_char   = r_orch;
    assign o_rsp.read_color  = r_orcol;
    assign o_rsp.scrolled    = r_oscr;

    // Cursor never runs beyond one past the last cell
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= C_CELLS)
        else $error("cursor beyond end of screen");

    // Column tracker stays in sync with the linear cursor at the end of screen
    a_col_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_colp <= C_COL_LAST) && ((r_cur != C_CELLS) || (r_colp == '0)))
        else $error("column tracker out of step with cursor");

    // A scrolled result leaves the cursor on the bottom row or just past it
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.scrolled) |-> (o_rsp.cursor_cell >= C_LAST_ROW))
        else $error("scroll left cursor above bottom row");

    // Read data is captured only in the cycle after its address was issued
    a_read_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDATA) |-> ($past(r_state) == S_RADDR))
        else $error("read data stage entered without address stage");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for text_console_writer_core: a queued command stream with random
// idling on both channels, each result checked against a bench-side console model.
// Depends on tcw_pkg, tcw_cmd_if / tcw_rsp_if and the core.
module testbench;
    import tcw_pkg::*;

    localparam int COLUMNS      = COLUMNS_DEF;
    localparam int ROWS         = ROWS_DEF;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int CELL_W       = $clog2(CELLS + 1);
    localparam int MAX_WAIT     = 11;
    localparam int RANDOM_ITEMS = 1250;
    localparam int REPORT_MAX   = 20;
    // Every transfer taking a full-screen pass plus both sides' longest idle, three times over
    localparam int LIMIT_CYCLES = (RANDOM_ITEMS + 100) * (CELLS + 2 * MAX_WAIT + 8) * 3;

    // Action codes that the core treats as no-ops
    localparam logic [ACTION_W-1:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   char_code;
        logic [BYTE_W-1:0]   color;
        logic [CELL_W-1:0]   cell_index;
    } t_console_cmd;

    typedef struct packed {
        logic [CELL_W-1:0] cursor_cell;
        logic [BYTE_W-1:0] read_char;
        logic [BYTE_W-1:0] read_color;
        logic              scrolled;
    } t_console_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tcw_cmd_if #(.CELL_W(CELL_W)) cmd_ch ();
    tcw_rsp_if #(.CELL_W(CELL_W)) rsp_ch ();

    text_console_writer_core #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_rsp  (rsp_ch)
    );

    // Bench copy of the screen planes and cursor
    logic [BYTE_W-1:0] scr_chars  [CELLS];
    logic [BYTE_W-1:0] scr_colors [CELLS];
    int                cursor_at = 0;

    t_console_cmd    command_q [$];
    t_console_result result_q  [$];

    int accepted_n  = 0;
    int command_n   = 0;
    int mismatch_n  = 0;
    int cycle_n     = 0;
    int send_wait   = 0;
    int send_calm   = 0;
    int recv_wait   = 0;
    int recv_calm   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one command to the bench console and return the result it must produce
    function automatic t_console_result console_step(t_console_cmd c);
        t_console_result r;
        r = '0;
        case (c.action)
            ACT_PRINT, ACT_PRINT_COLOR: begin
                // Scroll characters up one row when the cursor sits past the last cell
                if (cursor_at >= CELLS) begin
                    for (int i = COLUMNS; i < CELLS; i++) scr_chars[i - COLUMNS] = scr_chars[i];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++) scr_chars[i] = CHAR_BLANK;
                    cursor_at  = CELLS - COLUMNS;
                    r.scrolled = 1'b1;
                end
                if (c.char_code == CHAR_NEWLINE) begin
                    cursor_at = cursor_at + COLUMNS - (cursor_at % COLUMNS);
                end else begin
                    scr_chars[cursor_at] = c.char_code;
                    if (c.action == ACT_PRINT_COLOR) scr_colors[cursor_at] = c.color;
                    cursor_at++;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < CELLS; i++) scr_chars[i] = CHAR_BLANK;
                cursor_at = 0;
            end
            ACT_FILL: begin
                for (int i = 0; i < CELLS; i++) scr_colors[i] = c.color;
            end
            ACT_READ: begin
                if (int'(c.cell_index) < CELLS) begin
                    r.read_char  = scr_chars[c.cell_index];
                    r.read_color = scr_colors[c.cell_index];
                end
            end
            default: ;
        endcase
        r.cursor_cell = CELL_W'(cursor_at);
        return r;
    endfunction

    // Draw an idle count, with occasional stretches of back-to-back transfers
    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void queue_cmd(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] ch,
                                      logic [BYTE_W-1:0] col, logic [CELL_W-1:0] idx);
        command_q.push_back({act, ch, col, idx});
    endfunction

    task automatic report(string what, int got, int want);
        if (mismatch_n < REPORT_MAX)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_n, what, got, want);
        mismatch_n++;
    endtask

    // Command driver: predict each transfer, then load the next item after its idle gap
    always @(posedge i_clk) begin : drive_cmd
        t_console_cmd nxt;
        if (!i_rst_n) begin
            cmd_ch.valid      <= 1'b0;
            cmd_ch.action     <= '0;
            cmd_ch.char_code  <= '0;
            cmd_ch.color      <= '0;
            cmd_ch.cell_index <= '0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                result_q.push_back(console_step({cmd_ch.action, cmd_ch.char_code,
                                                 cmd_ch.color, cmd_ch.cell_index}));
                accepted_n++;
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    cmd_ch.valid <= 1'b0;
                end else if (command_q.size() != 0) begin
                    nxt = command_q.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.action     <= nxt.action;
                    cmd_ch.char_code  <= nxt.char_code;
                    cmd_ch.color      <= nxt.color;
                    cmd_ch.cell_index <= nxt.cell_index;
                    send_wait = draw_wait(send_calm);
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest prediction, then stall at random
    always @(posedge i_clk) begin : watch_rsp
        t_console_result want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b1;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            if (result_q.size() == 0) begin
                report("result with no command pending, cursor_cell", rsp_ch.cursor_cell, -1);
            end else begin
                want = result_q.pop_front();
                if (rsp_ch.cursor_cell !== want.cursor_cell)
                    report("cursor_cell", rsp_ch.cursor_cell, want.cursor_cell);
                if (rsp_ch.read_char !== want.read_char)
                    report("read_char", rsp_ch.read_char, want.read_char);
                if (rsp_ch.read_color !== want.read_color)
                    report("read_color", rsp_ch.read_color, want.read_color);
                if (rsp_ch.scrolled !== want.scrolled)
                    report("scrolled", rsp_ch.scrolled, want.scrolled);
            end
            recv_wait = draw_wait(recv_calm);
            rsp_ch.ready <= (recv_wait == 0);
        end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_ch.ready <= (recv_wait == 0);
        end
    end

    // Bound the run
    always @(posedge i_clk) begin : watchdog
        cycle_n++;
        if (cycle_n >= LIMIT_CYCLES) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int len;
        int base_n;
        int noise_n;
        logic [BYTE_W-1:0] ch;

        cmd_ch.valid      = 1'b0;
        cmd_ch.action     = '0;
        cmd_ch.char_code  = '0;
        cmd_ch.color      = '0;
        cmd_ch.cell_index = '0;
        rsp_ch.ready      = 1'b1;

        // Directed: define both planes first, then extremes and corner cases
        queue_cmd(ACT_CLEAR, 8'hFF, 8'hFF, '1);
        queue_cmd(ACT_FILL, 8'hFF, 8'h00, '1);
        queue_cmd(ACT_READ, 8'h00, 8'h00, '0);
        queue_cmd(ACT_READ, 8'hFF, 8'hFF, CELL_W'(CELLS - 1));
        queue_cmd(ACT_PRINT, 8'h41, 8'hFF, '1);
        queue_cmd(ACT_PRINT_COLOR, 8'hFF, 8'hFF, '0);
        queue_cmd(ACT_PRINT_COLOR, 8'h00, 8'h5A, '0);
        queue_cmd(ACT_READ, 8'h00, 8'h00, CELL_W'(0));
        queue_cmd(ACT_READ, 8'h00, 8'h00, CELL_W'(1));
        queue_cmd(ACT_READ, 8'h00, 8'h00, CELL_W'(2));
        // Newline writes no cell, not even its color
        queue_cmd(ACT_PRINT, CHAR_NEWLINE, 8'h00, '0);
        queue_cmd(ACT_PRINT_COLOR, CHAR_NEWLINE, 8'hA5, '0);
        queue_cmd(ACT_READ, 8'h00, 8'h00, CELL_W'(COLUMNS));
        queue_cmd(ACT_READ, 8'h00, 8'h00, CELL_W'(2 * COLUMNS));
        // Reads out of range return zeros
        queue_cmd(ACT_READ, 8'hFF, 8'hFF, CELL_W'(CELLS));
        queue_cmd(ACT_READ, 8'hFF, 8'hFF, '1);
        for (int a = ACT_RSVD_FIRST; a <= ACT_RSVD_LAST; a++)
            queue_cmd(ACTION_W'(a), 8'hFF, 8'hFF, '1);
        queue_cmd(ACT_FILL, 8'h00, 8'hFF, '0);
        queue_cmd(ACT_READ, 8'h00, 8'h00, CELL_W'(1));
        base_n  = command_q.size();
        noise_n = 0;

        // Random: mostly lines of text ending in newline, with reads, fills, clears and noise
        while (command_q.size() - base_n - noise_n < RANDOM_ITEMS) begin
            case ($urandom_range(0, 99)) inside
                [0:1]: queue_cmd(ACT_CLEAR, 8'($urandom), 8'($urandom), CELL_W'($urandom));
                [2:4]: queue_cmd(ACT_FILL, 8'($urandom), 8'($urandom), CELL_W'($urandom));
                [5:6]: begin
                    queue_cmd(ACTION_W'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST)),
                              8'($urandom), 8'($urandom), CELL_W'($urandom));
                    noise_n++;
                end
                [7:8]: begin
                    queue_cmd(ACT_READ, 8'($urandom), 8'($urandom),
                              CELL_W'($urandom_range(CELLS, (1 << CELL_W) - 1)));
                    noise_n++;
                end
                default: begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 170)
                                                      : $urandom_range(0, 12);
                    repeat (len) begin
                        if ($urandom_range(0, 7) == 0)
                            queue_cmd(ACT_READ, 8'($urandom), 8'($urandom),
                                      CELL_W'($urandom_range(0, CELLS - 1)));
                        ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(32, 126));
                        queue_cmd(($urandom_range(0, 2) == 0) ? ACT_PRINT_COLOR : ACT_PRINT,
                                  ch, 8'($urandom), CELL_W'($urandom));
                    end
                    queue_cmd(($urandom_range(0, 1) == 0) ? ACT_PRINT_COLOR : ACT_PRINT,
                              CHAR_NEWLINE, 8'($urandom), CELL_W'($urandom));
                end
            endcase
        end
        command_n = command_q.size();

        // Hold reset, then release and let the driver run
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_n < command_n || result_q.size() != 0) @(negedge i_clk);
        // Watch for stray results over one full-screen pass
        repeat (CELLS + 16) @(posedge i_clk);

        if (mismatch_n == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
